// ----- sv/dns_query_question_parser_macros.svh -----
// ----------------------------------------------------------------------------
// dns_query_question_parser_macros
// Assertion macros shared by the parser sources. Expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef DNS_QUERY_QUESTION_PARSER_MACROS_SVH
`define DNS_QUERY_QUESTION_PARSER_MACROS_SVH

// same-cycle implication
`define DQQP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DQQP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dqqp_pkg.sv -----
// ----------------------------------------------------------------------------
// dqqp_pkg
// Shared types and constants for the DNS query question parser.
// ----------------------------------------------------------------------------
package dqqp_pkg;

  localparam int NAME_BUFFER = 512;
  localparam int NL_W        = $clog2(NAME_BUFFER);
  localparam int NLX_W       = (NL_W > 9) ? NL_W : 9;
  localparam int LEN_SUM_W   = ((NL_W > 8) ? NL_W : 8) + 1;

  localparam int HDR_BYTES   = 12;
  localparam int MIN_MESSAGE = 26;
  localparam int TAIL_BYTES  = 4;
  localparam int COUNT_W     = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [8:0]         NAME_LENGTH_MAX = 9'd511;
  localparam logic [7:0]         DOT_CHAR = 8'h2e;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam logic REG_MAX_MESSAGE_LENGTH = 1'b0;
  localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 13'd512;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_BIG   = 3'd1;
  localparam logic [2:0] ST_TOO_SMALL = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_NAME  = 3'd4;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_char;
    logic [2:0]  status;
    logic [15:0] query_id;
    logic [15:0] qtype;
    logic [15:0] qclass;
    logic [8:0]  name_length;
    logic [31:0] reply_ip;
    logic [15:0] reply_port;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       a;
    res_t       b;
  } push_t;

endpackage

// ----- sv/dqqp_if.sv -----
// ----------------------------------------------------------------------------
// dqqp_if
// Valid/ready channels for message bytes and result items.
// ----------------------------------------------------------------------------
interface dqqp_msg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_byte;
  logic        msg_last;
  logic [31:0] src_ip;
  logic [15:0] src_port;

  modport source (output valid, msg_byte, msg_last, src_ip, src_port, input ready);
  modport sink   (input valid, msg_byte, msg_last, src_ip, src_port, output ready);
endinterface

interface dqqp_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  name_char;
  logic [2:0]  status;
  logic [15:0] query_id;
  logic [15:0] qtype;
  logic [15:0] qclass;
  logic [8:0]  name_length;
  logic [31:0] reply_ip;
  logic [15:0] reply_port;
  logic        last;

  modport source (output valid, result_kind, name_char, status, query_id, qtype,
                  qclass, name_length, reply_ip, reply_port, last, input ready);
  modport sink   (input valid, result_kind, name_char, status, query_id, qtype,
                  qclass, name_length, reply_ip, reply_port, last, output ready);
endinterface

// ----- sv/dqqp_cfg.sv -----
// ----------------------------------------------------------------------------
// dqqp_cfg
// APB register: largest accepted message length.
// ----------------------------------------------------------------------------
module dqqp_cfg
  import dqqp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [COUNT_W-1:0]    max_len
);

  logic sel_max_len;

  assign pready      = 1'b1;
  assign sel_max_len = (paddr[APB_ADDR_W-1] == REG_MAX_MESSAGE_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && sel_max_len) begin
      max_len <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = sel_max_len ? {{(32-COUNT_W){1'b0}}, max_len} : 32'd0;

endmodule

// ----- sv/dqqp_parser.sv -----
// ----------------------------------------------------------------------------
// dqqp_parser
// Per-byte header capture, label decode and type/class gather.
// ----------------------------------------------------------------------------
module dqqp_parser
  import dqqp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  dqqp_msg_if.sink           msg,
  input  logic [COUNT_W-1:0] max_len,
  input  logic               space,
  output push_t              push
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_LABEL  = 3'd2;
  localparam logic [2:0] PH_TAIL   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [2:0]         parse_phase, parse_phase_next;
  logic [7:0]         label_left, label_left_next;
  logic [NL_W-1:0]    name_len, name_len_next;
  logic [15:0]        header_id, header_id_next;
  logic [15:0]        question_count, question_count_next;
  logic [15:0]        answer_count, answer_count_next;
  logic [31:0]        type_class_word, type_class_word_next;
  logic [2:0]         tail_bytes, tail_bytes_next;
  logic               name_bad, name_bad_next;

  logic               fire;
  logic               emit;
  logic [7:0]         emit_char;
  logic [2:0]         status;
  logic [LEN_SUM_W-1:0] len_sum;
  logic [NLX_W-1:0]   nl;
  res_t               char_item;
  res_t               sum_item;

  assign msg.ready = space;
  assign fire      = msg.valid && msg.ready;
  assign len_sum   = LEN_SUM_W'(name_len) + LEN_SUM_W'(msg.msg_byte);
  assign nl        = (name_len != '0) ? NLX_W'(name_len - 1'b1) : '0;

  always_comb begin
    byte_count_next      = byte_count;
    parse_phase_next     = parse_phase;
    label_left_next      = label_left;
    name_len_next        = name_len;
    header_id_next       = header_id;
    question_count_next  = question_count;
    answer_count_next    = answer_count;
    type_class_word_next = type_class_word;
    tail_bytes_next      = tail_bytes;
    name_bad_next        = name_bad;
    emit                 = 1'b0;
    emit_char            = 8'd0;
    status               = ST_OK;

    if (fire) begin
      if (byte_count != COUNT_MAX) begin
        byte_count_next = byte_count + 1'b1;
      end
      case (parse_phase)
        PH_HEADER: begin
          case (byte_count[3:0])
            4'd0: header_id_next[15:8]      = msg.msg_byte;
            4'd1: header_id_next[7:0]       = msg.msg_byte;
            4'd4: question_count_next[15:8] = msg.msg_byte;
            4'd5: question_count_next[7:0]  = msg.msg_byte;
            4'd6: answer_count_next[15:8]   = msg.msg_byte;
            4'd7: answer_count_next[7:0]    = msg.msg_byte;
            default: ;
          endcase
          if (byte_count >= COUNT_W'(HDR_BYTES - 1)) begin
            parse_phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (msg.msg_byte == 8'd0) begin
            parse_phase_next = PH_TAIL;
            tail_bytes_next  = 3'd0;
          end else if (len_sum >= LEN_SUM_W'(NAME_BUFFER - 1)) begin
            name_bad_next    = 1'b1;
            parse_phase_next = PH_DONE;
          end else begin
            emit             = (name_len != '0);
            emit_char        = DOT_CHAR;
            label_left_next  = msg.msg_byte;
            parse_phase_next = PH_LABEL;
          end
        end
        PH_LABEL: begin
          emit            = 1'b1;
          emit_char       = msg.msg_byte;
          label_left_next = label_left - 1'b1;
          if (label_left_next == 8'd0) begin
            name_len_next    = name_len + NL_W'(2);
            parse_phase_next = PH_LEN;
          end else begin
            name_len_next    = name_len + 1'b1;
          end
        end
        PH_TAIL: begin
          type_class_word_next = {type_class_word[23:0], msg.msg_byte};
          tail_bytes_next      = tail_bytes + 1'b1;
          if (tail_bytes_next >= 3'(TAIL_BYTES)) begin
            parse_phase_next = PH_DONE;
          end
        end
        default: ;
      endcase

      if (byte_count_next > max_len) begin
        status = ST_TOO_BIG;
      end else if (byte_count_next < COUNT_W'(MIN_MESSAGE)) begin
        status = ST_TOO_SMALL;
      end else if (question_count_next != 16'd1 || answer_count_next != 16'd0) begin
        status = ST_BAD_COUNT;
      end else if (name_bad_next || parse_phase_next != PH_DONE) begin
        status = ST_BAD_NAME;
      end
    end
  end

  always_comb begin
    char_item             = '0;
    char_item.result_kind = KIND_CHAR;
    char_item.name_char   = emit_char;

    sum_item             = '0;
    sum_item.result_kind = KIND_SUMMARY;
    sum_item.status      = status;
    sum_item.query_id    = header_id_next;
    sum_item.reply_ip    = msg.src_ip;
    sum_item.reply_port  = msg.src_port;
    sum_item.last        = 1'b1;
    if (status == ST_OK) begin
      sum_item.qtype       = type_class_word_next[31:16];
      sum_item.qclass      = type_class_word_next[15:0];
      sum_item.name_length = (nl > NLX_W'(NAME_LENGTH_MAX)) ? NAME_LENGTH_MAX : nl[8:0];
    end

    push = '0;
    if (fire) begin
      if (emit) begin
        push.a   = char_item;
        push.b   = sum_item;
        push.cnt = msg.msg_last ? 2'd2 : 2'd1;
      end else begin
        push.a   = sum_item;
        push.b   = sum_item;
        push.cnt = msg.msg_last ? 2'd1 : 2'd0;
      end
    end
  end

  // summary fields are taken before the end-of-message clear
  always_ff @(posedge clk) begin
    if (rst || (fire && msg.msg_last)) begin
      byte_count      <= '0;
      parse_phase     <= PH_HEADER;
      label_left      <= 8'd0;
      name_len        <= '0;
      header_id       <= 16'd0;
      question_count  <= 16'd0;
      answer_count    <= 16'd0;
      type_class_word <= 32'd0;
      tail_bytes      <= 3'd0;
      name_bad        <= 1'b0;
    end else begin
      byte_count      <= byte_count_next;
      parse_phase     <= parse_phase_next;
      label_left      <= label_left_next;
      name_len        <= name_len_next;
      header_id       <= header_id_next;
      question_count  <= question_count_next;
      answer_count    <= answer_count_next;
      type_class_word <= type_class_word_next;
      tail_bytes      <= tail_bytes_next;
      name_bad        <= name_bad_next;
    end
  end

endmodule

// ----- sv/dqqp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// dqqp_out_fifo
// Result queue; takes up to two items per cycle, delivers one per transfer.
// ----------------------------------------------------------------------------
`include "dns_query_question_parser_macros.svh"

module dqqp_out_fifo
  import dqqp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  dqqp_res_if.source res,
  output logic       space
);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W:0]   fill_sum;
  logic                  pop;
  res_t                  head;

  assign pop      = res.valid && res.ready;
  assign space    = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign fill_sum = {1'b0, count} + (FIFO_CNT_W + 1)'(push.cnt);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
    end
  end

  assign head            = mem[rd_ptr];
  assign res.valid       = (count != '0);
  assign res.result_kind = head.result_kind;
  assign res.name_char   = head.name_char;
  assign res.status      = head.status;
  assign res.query_id    = head.query_id;
  assign res.qtype       = head.qtype;
  assign res.qclass      = head.qclass;
  assign res.name_length = head.name_length;
  assign res.reply_ip    = head.reply_ip;
  assign res.reply_port  = head.reply_port;
  assign res.last        = head.last;

  `DQQP_ASSERT_NOW(a_no_overflow, push.cnt != 2'd0, fill_sum <= (FIFO_CNT_W + 1)'(FIFO_DEPTH), "result queue overflow")
  `DQQP_ASSERT_NOW(a_pair_order, push.cnt == 2'd2, push.a.result_kind == KIND_CHAR && push.b.last, "paired push not char then summary")
  `DQQP_ASSERT_NEXT(a_fill_grows, push.cnt != 2'd0 && !pop, count > $past(count), "queue fill did not grow on push")

endmodule

// ----- sv/dns_query_question_parser.sv -----
// ----------------------------------------------------------------------------
// dns_query_question_parser
// DNS request parser: header capture, first question name, type and class.
// ----------------------------------------------------------------------------
// Usage
//   msg: one message byte per transfer, msg_last on the final byte, with the
//   sender address and port. res: decoded name characters (result_kind 0,
//   a dot between labels), then one summary item (result_kind 1, last 1) on
//   the final byte. A non-ok status means the characters already delivered
//   for that message are to be dropped.
//   Throughput: one byte per cycle while the result queue has room. Each
//   result passes through the result queue. A final byte that also yields a
//   character gives two results, delivered on consecutive transfers.
//   A four-entry result queue separates the sides; msg.ready falls while it
//   has fewer than two free entries, so a stalled receiver holds off input.
//   Reset: parser to header phase, queue empty, max_message_length 512. The
//   register is to be written over APB between messages only (not enforced).
// ----------------------------------------------------------------------------
module dns_query_question_parser
  import dqqp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  dqqp_msg_if.sink              msg,
  dqqp_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [COUNT_W-1:0] max_len;
  logic               space;
  push_t              push;

  dqqp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  dqqp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg),
    .max_len (max_len),
    .space   (space),
    .push    (push)
  );

  dqqp_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .res   (res),
    .space (space)
  );

endmodule

// ----- bench/tb_dns_query_question_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_query_question_parser
// Self-checking bench for the DNS query question parser. Whole messages are
// queued as byte transfers and driven with random idle bursts on both
// channels. A local decoder tracks header, name, type/class and byte count
// and predicts every name character and summary, and each result is checked
// field by field. Directed messages cover the status order, name limits
// and truncation. Random traffic follows under several max_message_length
// settings, written and read back over APB.
// ----------------------------------------------------------------------------
module tb_dns_query_question_parser;
  import dqqp_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam logic [APB_ADDR_W-1:0] MAXLEN_ADDR = APB_ADDR_W'(4 * REG_MAX_MESSAGE_LENGTH);

  typedef enum logic [2:0] {
    AT_HEADER,
    AT_LENGTH,
    AT_LABEL,
    AT_TAIL,
    AT_DONE
  } parse_at_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    logic [31:0] ip;
    logic [15:0] port;
  } msg_item_t;

  logic clk = 1'b0;
  logic rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  dqqp_msg_if msg_ch ();
  dqqp_res_if res_ch ();

  dns_query_question_parser DUT (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // decoder state
  logic [COUNT_W-1:0] max_len_cfg;
  logic [COUNT_W-1:0] seen_bytes;
  parse_at_t          parse_at;
  logic [7:0]         label_left;
  int unsigned        name_chars;
  logic [15:0]        hdr_id;
  logic [15:0]        qd_count;
  logic [15:0]        an_count;
  logic [31:0]        type_class;
  int unsigned        tail_seen;
  logic               name_overflow;

  res_t      awaited[$];
  msg_item_t byte_backlog[$];
  logic [7:0] frame[$];
  int        outstanding = 0;
  int        fault_count = 0;
  int        cycle_count = 0;
  logic      quiet = 1'b0;
  logic      msg_took = 1'b0;
  int        send_gap = 0;
  int        stall_left = 0;
  msg_item_t nxt;
  res_t      got_res;
  res_t      want_res;

  function automatic void reset_parse();
    seen_bytes    = '0;
    parse_at      = AT_HEADER;
    label_left    = '0;
    name_chars    = 0;
    hdr_id        = '0;
    qd_count      = '0;
    an_count      = '0;
    type_class    = '0;
    tail_seen     = 0;
    name_overflow = 1'b0;
  endfunction

  function automatic void push_char(logic [7:0] ch);
    res_t r;
    r = '0;
    r.result_kind = KIND_CHAR;
    r.name_char   = ch;
    awaited.push_back(r);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin, logic [31:0] ip,
                                      logic [15:0] port);
    res_t        r;
    int unsigned idx;
    int unsigned nl;
    logic [2:0]  st;
    idx = seen_bytes;
    if (seen_bytes < COUNT_MAX) seen_bytes++;
    case (parse_at)
      AT_HEADER: begin
        case (idx)
          0: hdr_id = {b, 8'h00};
          1: hdr_id = hdr_id | {8'h00, b};
          4: qd_count = {b, 8'h00};
          5: qd_count = qd_count | {8'h00, b};
          6: an_count = {b, 8'h00};
          7: an_count = an_count | {8'h00, b};
          default: ;
        endcase
        if (idx + 1 >= HDR_BYTES) parse_at = AT_LENGTH;
      end
      AT_LENGTH: begin
        if (b == 8'd0) begin
          parse_at  = AT_TAIL;
          tail_seen = 0;
        end else if (name_chars + b >= NAME_BUFFER - 1) begin
          name_overflow = 1'b1;
          parse_at      = AT_DONE;
        end else begin
          if (name_chars > 0) push_char(DOT_CHAR);
          label_left = b;
          parse_at   = AT_LABEL;
        end
      end
      AT_LABEL: begin
        push_char(b);
        name_chars++;
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) begin
          name_chars++;
          parse_at = AT_LENGTH;
        end
      end
      AT_TAIL: begin
        type_class = {type_class[23:0], b};
        tail_seen++;
        if (tail_seen >= TAIL_BYTES) parse_at = AT_DONE;
      end
      default: ;
    endcase

    if (fin) begin
      if (seen_bytes > max_len_cfg) st = ST_TOO_BIG;
      else if (seen_bytes < MIN_MESSAGE) st = ST_TOO_SMALL;
      else if (qd_count != 16'd1 || an_count != 16'd0) st = ST_BAD_COUNT;
      else if (name_overflow || parse_at != AT_DONE) st = ST_BAD_NAME;
      else st = ST_OK;
      r = '0;
      r.result_kind = KIND_SUMMARY;
      r.status      = st;
      r.query_id    = hdr_id;
      if (st == ST_OK) begin
        nl = (name_chars > 0) ? name_chars - 1 : 0;
        if (nl > NAME_LENGTH_MAX) nl = NAME_LENGTH_MAX;
        r.qtype       = type_class[31:16];
        r.qclass      = type_class[15:0];
        r.name_length = nl[8:0];
      end
      r.reply_ip   = ip;
      r.reply_port = port;
      r.last       = 1'b1;
      awaited.push_back(r);
      reset_parse();
    end
  endfunction

  // message builders
  function automatic void put_bytes(int n);
    repeat (n) frame.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_header(logic [15:0] id, logic [15:0] qd, logic [15:0] an);
    frame.push_back(id[15:8]);
    frame.push_back(id[7:0]);
    put_bytes(2);
    frame.push_back(qd[15:8]);
    frame.push_back(qd[7:0]);
    frame.push_back(an[15:8]);
    frame.push_back(an[7:0]);
    put_bytes(4);
  endfunction

  function automatic void put_label(int len);
    frame.push_back(8'(len));
    put_bytes(len);
  endfunction

  function automatic void put_name_end();
    frame.push_back(8'd0);
    put_bytes(TAIL_BYTES);
  endfunction

  function automatic void pad_to(int total);
    if (frame.size() < total) put_bytes(total - frame.size());
  endfunction

  function automatic void ship_frame();
    msg_item_t it;
    foreach (frame[i]) begin
      it.b    = frame[i];
      it.fin  = (i == frame.size() - 1);
      it.ip   = $urandom;
      it.port = 16'($urandom_range(0, 65535));
      byte_backlog.push_back(it);
      outstanding++;
    end
    frame.delete();
  endfunction

  function automatic int random_frame();
    int pick;
    int len;
    int cut;
    int n;
    pick = $urandom_range(0, 99);
    if (pick >= 95) begin
      put_bytes($urandom_range(1, 60));
    end else begin
      if (pick >= 75 && pick < 85)
        put_header(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
      else
        put_header(16'($urandom_range(0, 65535)), 16'd1, 16'd0);
      repeat ($urandom_range(0, 4)) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 255) : $urandom_range(1, 20);
        put_label(len);
      end
      put_name_end();
      if ($urandom_range(0, 1)) pad_to(MIN_MESSAGE);
      put_bytes($urandom_range(0, 3));
      if (pick >= 85) begin
        cut = $urandom_range(1, frame.size() - 1);
        frame = frame[0:cut-1];
      end
    end
    n = frame.size();
    ship_frame();
    return n;
  endfunction

  task automatic random_traffic(int budget);
    while (budget > 0) budget -= random_frame();
  endtask

  task automatic settle();
    wait (outstanding == 0 && awaited.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_len_cfg = value[COUNT_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== value[COUNT_W-1:0]) begin
      $error("max_message_length readback expected %0d actual %0d",
             value[COUNT_W-1:0], prdata[COUNT_W-1:0]);
      fault_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", fname, want, got);
      fault_count++;
    end
  endfunction

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      msg_ch.valid <= 1'b0;
    end else if (!msg_ch.valid || msg_took) begin
      if (send_gap > 0) begin
        send_gap--;
        msg_ch.valid <= 1'b0;
      end else if (byte_backlog.size() == 0) begin
        msg_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        msg_ch.valid <= 1'b0;
      end else begin
        nxt = byte_backlog.pop_front();
        msg_ch.valid    <= 1'b1;
        msg_ch.msg_byte <= nxt.b;
        msg_ch.msg_last <= nxt.fin;
        msg_ch.src_ip   <= nxt.ip;
        msg_ch.src_port <= nxt.port;
      end
    end
  end

  // result ready with stall bursts
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // byte transfers feed the decoder
  always @(posedge clk) begin
    cycle_count++;
    msg_took = !rst && msg_ch.valid && msg_ch.ready;
    if (msg_took) begin
      decode_byte(msg_ch.msg_byte, msg_ch.msg_last, msg_ch.src_ip, msg_ch.src_port);
      outstanding--;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_res.result_kind = res_ch.result_kind;
      got_res.name_char   = res_ch.name_char;
      got_res.status      = res_ch.status;
      got_res.query_id    = res_ch.query_id;
      got_res.qtype       = res_ch.qtype;
      got_res.qclass      = res_ch.qclass;
      got_res.name_length = res_ch.name_length;
      got_res.reply_ip    = res_ch.reply_ip;
      got_res.reply_port  = res_ch.reply_port;
      got_res.last        = res_ch.last;
      if (awaited.size() == 0) begin
        $error("result transfer with nothing awaited, result_kind %0d", got_res.result_kind);
        fault_count++;
      end else begin
        want_res = awaited.pop_front();
        check_field("result_kind", want_res.result_kind, got_res.result_kind);
        check_field("name_char",   want_res.name_char,   got_res.name_char);
        check_field("status",      want_res.status,      got_res.status);
        check_field("query_id",    want_res.query_id,    got_res.query_id);
        check_field("qtype",       want_res.qtype,       got_res.qtype);
        check_field("qclass",      want_res.qclass,      got_res.qclass);
        check_field("name_length", want_res.name_length, got_res.name_length);
        check_field("reply_ip",    want_res.reply_ip,    got_res.reply_ip);
        check_field("reply_port",  want_res.reply_port,  got_res.reply_port);
        check_field("last",        want_res.last,        got_res.last);
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    msg_ch.valid    = 1'b0;
    msg_ch.msg_byte = '0;
    msg_ch.msg_last = 1'b0;
    msg_ch.src_ip   = '0;
    msg_ch.src_port = '0;
    res_ch.ready    = 1'b0;
    max_len_cfg     = MAX_LEN_RESET;
    reset_parse();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limit of 512
    put_header(16'h0000, 16'd1, 16'd0); put_label(8); put_name_end(); ship_frame();
    put_header(16'hffff, 16'd1, 16'd0); put_label(3); put_label(5); put_label(3);
    put_name_end(); put_bytes(3); ship_frame();
    put_header(16'h1234, 16'd1, 16'd0); put_label(7); frame.push_back(8'd0); ship_frame();
    put_bytes(1); ship_frame();
    put_header(16'ha5a5, 16'd0, 16'd0); put_label(10); put_name_end(); ship_frame();
    put_header(16'h5a5a, 16'd2, 16'd0); put_label(10); put_name_end(); ship_frame();
    put_header(16'h0f0f, 16'h0101, 16'd0); put_label(10); put_name_end(); ship_frame();
    put_header(16'hf0f0, 16'd1, 16'd1); put_label(10); put_name_end(); ship_frame();
    put_header(16'h8001, 16'd1, 16'hffff); put_label(10); put_name_end(); ship_frame();
    // ends inside a label: last byte gives a character and the summary
    put_header(16'h7777, 16'd1, 16'd0); put_label(30); frame = frame[0:32]; ship_frame();
    // ends inside type/class
    put_header(16'h6666, 16'd1, 16'd0); put_label(10); frame.push_back(8'd0);
    put_bytes(2); ship_frame();
    // label lengths above 63
    put_header(16'h4444, 16'd1, 16'd0); put_label(64); put_name_end(); ship_frame();
    // empty name
    put_header(16'h3333, 16'd1, 16'd0); put_name_end(); pad_to(MIN_MESSAGE); ship_frame();
    // name buffer overflow
    put_header(16'h2222, 16'd1, 16'd0); put_label(255); frame.push_back(8'd255);
    put_bytes(10); ship_frame();
    // too small ahead of counts
    put_header(16'h1114, 16'd0, 16'd3); put_bytes(8); ship_frame();

    settle();
    write_reg(MAXLEN_ADDR, 32'(MIN_MESSAGE));
    // length limit edges, too big ahead of counts
    put_header(16'h0102, 16'd1, 16'd0); put_label(8); put_name_end(); ship_frame();
    put_header(16'h0103, 16'd1, 16'd0); put_label(9); put_name_end(); ship_frame();
    put_header(16'h1113, 16'd0, 16'd3); put_label(10); put_name_end(); ship_frame();

    settle();
    write_reg(MAXLEN_ADDR, 32'($urandom_range(MIN_MESSAGE, 4096)));
    random_traffic(100);

    settle();
    write_reg(MAXLEN_ADDR, 32'($urandom_range(MIN_MESSAGE, 60)));
    random_traffic(90);

    settle();
    write_reg(MAXLEN_ADDR, 32'(MAX_LEN_RESET));
    quiet = 1'b1;
    random_traffic(80);

    settle();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/dqqp_pkg.sv
sv/dqqp_if.sv
sv/dqqp_cfg.sv
sv/dqqp_parser.sv
sv/dqqp_out_fifo.sv
sv/dns_query_question_parser.sv
bench/tb_dns_query_question_parser.sv
